### rtl/bad_pkg.sv
// shared types and constants of the box average downsampler
package bad_pkg;

   // sizes of the image and of the block
   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_FACTOR    = 16;
   localparam int MAX_OUT_WIDTH = 2048;

   // field widths
   localparam int SIZE_W   = 13;
   localparam int FACTOR_W = 5;
   localparam int SAMPLE_W = 8;
   localparam int CSR_IDX_W = 2;

   // derived widths
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int SLOT_W   = $clog2(MAX_OUT_WIDTH);
   localparam int CIB_W    = $clog2(MAX_FACTOR);
   localparam int CNT_W    = 2 * CIB_W + 1;
   localparam int PART_W   = SAMPLE_W + CIB_W;
   localparam int SUM_W    = SAMPLE_W + 2 * CIB_W;
   localparam int STEP_W   = $clog2(COL_W);
   localparam int DIV_CNT_W = $clog2(SUM_W);

   // command queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BLOCK_FACTOR = 2'd2,
      CSR_COLOR_MODE   = 2'd3
   } csr_index_type;

   // one closed row segment of a block, handed from front to back
   typedef struct packed {
      logic [SLOT_W-1:0]            slot;
      logic                         first_row;
      logic                         row_end;
      logic [CNT_W-1:0]             count;
      logic [SLOT_W-1:0]            out_column;
      logic [SLOT_W-1:0]            out_row;
      logic                         image_done;
      logic [2:0][PART_W-1:0]       partial;
   } cmd_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // back end sequencer
   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ACC,
      BACK_DIV,
      BACK_OUT
   } back_state_type;

endpackage

### rtl/bad_if.sv
// pixel and reduced pixel channel interfaces
interface bad_req_if;
   import bad_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_zero;
   logic [SAMPLE_W-1:0] sample_one;
   logic [SAMPLE_W-1:0] sample_two;
   modport source (output valid, output sample_zero, output sample_one,
                   output sample_two, input ready);
   modport sink   (input valid, input sample_zero, input sample_one,
                   input sample_two, output ready);
endinterface

interface bad_rsp_if;
   import bad_pkg::*;
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   out_column;
   logic [SLOT_W-1:0]   out_row;
   logic [SAMPLE_W-1:0] average_zero;
   logic [SAMPLE_W-1:0] average_one;
   logic [SAMPLE_W-1:0] average_two;
   logic                image_done;
   modport source (output valid, output out_column, output out_row,
                   output average_zero, output average_one, output average_two,
                   output image_done, input ready);
   modport sink   (input valid, input out_column, input out_row,
                   input average_zero, input average_one, input average_two,
                   input image_done, output ready);
endinterface

### rtl/bad_front.sv
// front end: configuration, raster position tracking and row segment sums
module bad_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [bad_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bad_pkg::SIZE_W-1:0]      csr_write_data,
   bad_req_if.sink                         req,
   input  bad_pkg::fifo_status_type        fifo_status,
   output logic                            push,
   output bad_pkg::cmd_type                push_cmd
);
   import bad_pkg::*;

   // configuration registers
   logic [SIZE_W-1:0]   width_ff, width_in;
   logic [SIZE_W-1:0]   height_ff, height_in;
   logic [FACTOR_W-1:0] factor_ff, factor_in;
   logic                color_ff, color_in;

   // position state
   logic [COL_W-1:0]    sc_ff, sc_in;
   logic [COL_W-1:0]    sr_ff, sr_in;
   logic [CIB_W-1:0]    cib_ff, cib_in;
   logic [CIB_W-1:0]    rib_ff, rib_in;
   logic [SLOT_W-1:0]   qc_ff, qc_in;
   logic [CIB_W-1:0]    rc_ff, rc_in;
   logic [SLOT_W-1:0]   qr_ff, qr_in;
   logic [CIB_W-1:0]    rr_ff, rr_in;
   logic [2:0][PART_W-1:0] rp_ff, rp_in;

   // quotient recompute after a configuration write
   logic                recalc_ff, recalc_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COL_W-1:0]    col_div_ff, col_div_in;
   logic [FACTOR_W-1:0] col_rem_ff, col_rem_in;
   logic [COL_W-1:0]    row_div_ff, row_div_in;
   logic [FACTOR_W-1:0] row_rem_ff, row_rem_in;

   logic [SIZE_W-1:0]   wc, hc;
   logic [FACTOR_W-1:0] fc;
   logic                last_col, last_row, col_end, row_end, accept;
   logic [2:0][SAMPLE_W-1:0] smp;
   logic [2:0][PART_W-1:0]   part_new;
   logic [CIB_W:0]      cib1, rib1, rc1, rr1;
   logic [2*CIB_W+1:0]  prod;
   logic [FACTOR_W:0]   col_sh, row_sh, col_diff, row_diff;
   logic                col_ge, row_ge;

   // clamped sizes
   always_comb begin
      if (width_ff == '0) wc = SIZE_W'(1);
      else if (width_ff > SIZE_W'(MAX_WIDTH)) wc = SIZE_W'(MAX_WIDTH);
      else wc = width_ff;
      if (height_ff == '0) hc = SIZE_W'(1);
      else if (height_ff > SIZE_W'(MAX_WIDTH)) hc = SIZE_W'(MAX_WIDTH);
      else hc = height_ff;
      if (factor_ff < FACTOR_W'(2)) fc = FACTOR_W'(2);
      else if (factor_ff > FACTOR_W'(MAX_FACTOR)) fc = FACTOR_W'(MAX_FACTOR);
      else fc = factor_ff;
   end

   // item classification
   assign cib1     = {1'b0, cib_ff} + (CIB_W+1)'(1);
   assign rib1     = {1'b0, rib_ff} + (CIB_W+1)'(1);
   assign rc1      = {1'b0, rc_ff} + (CIB_W+1)'(1);
   assign rr1      = {1'b0, rr_ff} + (CIB_W+1)'(1);
   assign last_col = ({1'b0, sc_ff} + SIZE_W'(1)) >= wc;
   assign last_row = ({1'b0, sr_ff} + SIZE_W'(1)) >= hc;
   assign col_end  = last_col || (cib1 >= fc);
   assign row_end  = last_row || (rib1 >= fc);
   assign prod     = {{(CIB_W+1){1'b0}}, cib1} * {{(CIB_W+1){1'b0}}, rib1};

   assign smp[0] = req.sample_zero;
   assign smp[1] = color_ff ? req.sample_one : '0;
   assign smp[2] = color_ff ? req.sample_two : '0;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         part_new[i] = rp_ff[i] + {{CIB_W{1'b0}}, smp[i]};
      end
   end

   // handshake
   assign req.ready = !fifo_status.full && !recalc_ff;
   assign accept    = req.valid && req.ready;
   assign push      = accept && col_end;

   // command for the back end
   always_comb begin
      push_cmd.slot       = qc_ff;
      push_cmd.first_row  = (rib_ff == '0);
      push_cmd.row_end    = row_end;
      push_cmd.count      = prod[CNT_W-1:0];
      push_cmd.out_column = qc_ff;
      push_cmd.out_row    = qr_ff;
      push_cmd.image_done = last_col && last_row;
      push_cmd.partial    = part_new;
   end

   // one restoring division step for column and row
   always_comb begin
      col_sh   = {col_rem_ff, col_div_ff[COL_W-1]};
      row_sh   = {row_rem_ff, row_div_ff[COL_W-1]};
      col_ge   = col_sh >= {1'b0, fc};
      row_ge   = row_sh >= {1'b0, fc};
      col_diff = col_sh - {1'b0, fc};
      row_diff = row_sh - {1'b0, fc};
   end

   // next state
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      factor_in  = factor_ff;
      color_in   = color_ff;
      sc_in      = sc_ff;
      sr_in      = sr_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      qc_in      = qc_ff;
      rc_in      = rc_ff;
      qr_in      = qr_ff;
      rr_in      = rr_ff;
      rp_in      = rp_ff;
      recalc_in  = recalc_ff;
      step_in    = step_ff;
      col_div_in = col_div_ff;
      col_rem_in = col_rem_ff;
      row_div_in = row_div_ff;
      row_rem_in = row_rem_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            CSR_BLOCK_FACTOR: factor_in = csr_write_data[FACTOR_W-1:0];
            CSR_COLOR_MODE:   color_in  = csr_write_data[0];
            default:          width_in  = width_ff;
         endcase
         // block quotients are rebuilt after any register write to follow the new settings
         recalc_in  = 1'b1;
         step_in    = '0;
         col_div_in = sc_ff;
         col_rem_in = '0;
         row_div_in = sr_ff;
         row_rem_in = '0;
      end else if (recalc_ff) begin
         col_rem_in = col_ge ? col_diff[FACTOR_W-1:0] : col_sh[FACTOR_W-1:0];
         row_rem_in = row_ge ? row_diff[FACTOR_W-1:0] : row_sh[FACTOR_W-1:0];
         col_div_in = {col_div_ff[COL_W-2:0], col_ge};
         row_div_in = {row_div_ff[COL_W-2:0], row_ge};
         step_in    = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(COL_W - 1)) begin
            recalc_in = 1'b0;
            qc_in     = col_div_in[SLOT_W-1:0];
            rc_in     = col_rem_in[CIB_W-1:0];
            qr_in     = row_div_in[SLOT_W-1:0];
            rr_in     = row_rem_in[CIB_W-1:0];
         end
      end

      if (accept) begin
         // segment bookkeeping
         if (col_end) begin
            rp_in  = '0;
            cib_in = '0;
         end else begin
            rp_in  = part_new;
            cib_in = cib1[CIB_W-1:0];
         end
         // raster position
         if (last_col) begin
            sc_in  = '0;
            qc_in  = '0;
            rc_in  = '0;
            rib_in = row_end ? '0 : rib1[CIB_W-1:0];
            if (last_row) begin
               sr_in  = '0;
               qr_in  = '0;
               rr_in  = '0;
               rib_in = '0;
            end else begin
               sr_in = sr_ff + COL_W'(1);
               if (rr1 >= fc) begin
                  rr_in = '0;
                  qr_in = qr_ff + SLOT_W'(1);
               end else begin
                  rr_in = rr1[CIB_W-1:0];
               end
            end
         end else begin
            sc_in = sc_ff + COL_W'(1);
            if (rc1 >= fc) begin
               rc_in = '0;
               qc_in = qc_ff + SLOT_W'(1);
            end else begin
               rc_in = rc1[CIB_W-1:0];
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
         factor_ff <= FACTOR_W'(2);
         color_ff  <= 1'b0;
         sc_ff     <= '0;
         sr_ff     <= '0;
         cib_ff    <= '0;
         rib_ff    <= '0;
         qc_ff     <= '0;
         rc_ff     <= '0;
         qr_ff     <= '0;
         rr_ff     <= '0;
         rp_ff     <= '0;
         recalc_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         factor_ff <= factor_in;
         color_ff  <= color_in;
         sc_ff     <= sc_in;
         sr_ff     <= sr_in;
         cib_ff    <= cib_in;
         rib_ff    <= rib_in;
         qc_ff     <= qc_in;
         rc_ff     <= rc_in;
         qr_ff     <= qr_in;
         rr_ff     <= rr_in;
         rp_ff     <= rp_in;
         recalc_ff <= recalc_in;
         step_ff   <= step_in;
      end
   end

   // division working registers
   always_ff @(posedge clock) begin
      col_div_ff <= col_div_in;
      col_rem_ff <= col_rem_in;
      row_div_ff <= row_div_in;
      row_rem_ff <= row_rem_in;
   end

`ifndef ASSERT_OFF
   // no pixel is taken right after a register write, as the quotient rebuild starts
   a_no_transfer_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> !(req.valid && req.ready))
      else $error("pixel transfer during quotient recompute");
`endif

endmodule

### rtl/bad_fifo.sv
// short command queue between front and back end
module bad_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bad_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output bad_pkg::cmd_type          head,
   output bad_pkg::fifo_status_type  status
);
   import bad_pkg::*;

   cmd_type              entries [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in;
   logic [FIFO_AW-1:0]   rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;

   // pointers and fill level
   always_comb begin
      wr_in  = push ? wr_ff + FIFO_AW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + FIFO_AW'(1) : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ff] <= push_cmd;
      end
   end

   assign head         = entries[rd_ff];
   assign status.full  = (cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("command queue underflow");
`endif

endmodule

### rtl/bad_back.sv
// back end: line store update, block mean division and result register
module bad_back (
   input  logic                      clock,
   input  logic                      reset,
   input  bad_pkg::fifo_status_type  fifo_status,
   input  bad_pkg::cmd_type          head,
   output logic                      pop,
   bad_rsp_if.source                 rsp
);
   import bad_pkg::*;

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff;
   logic [2:0][SUM_W-1:0]  rd_ff;
   logic [2:0][SUM_W-1:0]  div_ff, div_in;
   logic [2:0][CNT_W-1:0]  rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   step_ff, step_in;
   logic [2:0][SUM_W-1:0]  sum;
   logic [2:0][SAMPLE_W-1:0] avg;
   logic [CNT_W:0]         sh [3];
   logic [CNT_W:0]         diff [3];
   logic                   mem_read, mem_write, div_load, div_run, last_step;

   // line store of column sums
   logic [3*SUM_W-1:0]     sums_mem [MAX_OUT_WIDTH];

   assign last_step = (step_ff == DIV_CNT_W'(SUM_W - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: if (!fifo_status.empty) state_in = BACK_ACC;
         BACK_ACC:  state_in = cmd_ff.row_end ? BACK_DIV : BACK_IDLE;
         BACK_DIV:  if (last_step) state_in = BACK_OUT;
         BACK_OUT:  if (rsp.ready) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mem_read  = 1'b0;
      mem_write = 1'b0;
      div_load  = 1'b0;
      div_run   = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         BACK_IDLE: mem_read = !fifo_status.empty;
         BACK_ACC: begin
            mem_write = 1'b1;
            div_load  = cmd_ff.row_end;
         end
         BACK_DIV:  div_run   = 1'b1;
         BACK_OUT:  rsp.valid = 1'b1;
         default:   rsp.valid = 1'b0;
      endcase
   end

   assign pop = mem_read;

   // new column sums
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = cmd_ff.first_row ? {{CIB_W{1'b0}}, cmd_ff.partial[i]}
                                   : rd_ff[i] + {{CIB_W{1'b0}}, cmd_ff.partial[i]};
      end
   end

   // restoring division, one quotient bit per cycle on each channel
   always_comb begin
      div_in  = div_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      for (int i = 0; i < 3; i++) begin
         sh[i]   = {rem_ff[i], div_ff[i][SUM_W-1]};
         diff[i] = sh[i] - {1'b0, cmd_ff.count};
      end
      if (div_load) begin
         div_in  = sum;
         rem_in  = '0;
         step_in = '0;
      end else if (div_run) begin
         step_in = step_ff + DIV_CNT_W'(1);
         for (int i = 0; i < 3; i++) begin
            if (sh[i] >= {1'b0, cmd_ff.count}) begin
               rem_in[i] = diff[i][CNT_W-1:0];
               div_in[i] = {div_ff[i][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = sh[i][CNT_W-1:0];
               div_in[i] = {div_ff[i][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (mem_read) begin
         cmd_ff <= head;
      end
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   // line store ports
   always_ff @(posedge clock) begin
      if (mem_read) begin
         rd_ff <= sums_mem[head.slot];
      end
      if (mem_write) begin
         sums_mem[cmd_ff.slot] <= sum;
      end
   end

   // saturated means
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         avg[i] = (|div_ff[i][SUM_W-1:SAMPLE_W]) ? '1 : div_ff[i][SAMPLE_W-1:0];
      end
   end

   assign rsp.out_column   = cmd_ff.out_column;
   assign rsp.out_row      = cmd_ff.out_row;
   assign rsp.average_zero = avg[0];
   assign rsp.average_one  = avg[1];
   assign rsp.average_two  = avg[2];
   assign rsp.image_done   = cmd_ff.image_done;

`ifndef ASSERT_OFF
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_ACC && cmd_ff.row_end) |-> (cmd_ff.count != '0))
      else $error("block mean with zero pixel count");
`endif

endmodule

### rtl/box_average_downsampler.sv
// top level of the box average downsampler
// Usage:
//   req_chan carries source pixels in raster order, one per transfer, as three
//   8-bit samples; channels one and two are ignored in grayscale mode.
//   rsp_chan carries one reduced pixel per completed block: its column and row,
//   the truncated channel means and image_done on the last one of the image.
//   The csr port writes image width, image height, block factor and colour mode
//   by index; write only while no block is in flight. After each write the
//   block rebuilds its block quotients and takes no pixel until the rebuild is done.
// Flow:
//   A pixel that closes a block row segment queues a command; the back end
//   reads the line store in its idle state and writes it back in its
//   accumulate state, and when the segment also closes the block it runs the
//   per-block division and then presents the result. Apart from the rebuild
//   after a write, pixel intake stalls only when the four-entry command queue
//   is full.
// Reset clears positions and sums and loads 640x480, factor 2, grayscale; the
//   line store is not cleared. A stalled receiver holds the result register,
//   the back end waits and the front keeps taking pixels until the queue fills.
module box_average_downsampler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [bad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bad_pkg::SIZE_W-1:0]     csr_write_data,
   bad_req_if.sink                        req_chan,
   bad_rsp_if.source                      rsp_chan
);
   import bad_pkg::*;

   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head;
   fifo_status_type  fifo_status;

   // pixel intake and classification
   bad_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .fifo_status      (fifo_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // command queue
   bad_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (fifo_status)
   );

   // accumulation and division
   bad_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .head        (head),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule

### tb/pixel_block_checker.sv
// checker of the box average downsampler: predicts reduced pixels and compares them
`timescale 1ns / 100ps

module pixel_block_checker
   import bad_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_write_data,
   bad_req_if                   req_mon,
   bad_rsp_if                   rsp_mon,
   output int                   fail_count,
   output int                   pending_count
);

   typedef struct {
      logic [SLOT_W-1:0]   column;
      logic [SLOT_W-1:0]   row;
      logic [SAMPLE_W-1:0] mean [3];
      logic                done;
   } reduced_pixel_type;

   // mirrored registers
   int unsigned width_reg, height_reg, factor_reg;
   logic        rgb_mode;

   // mirrored accumulation state
   int unsigned block_column_sums [MAX_OUT_WIDTH][3];
   int unsigned segment_sums [3];
   int unsigned pixel_column, pixel_row, column_offset, row_offset;

   reduced_pixel_type reduced_pixel_queue [$];

   function automatic int unsigned clamp_size(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   function automatic int unsigned clamp_factor(int unsigned v);
      if (v < 2) return 2;
      if (v > MAX_FACTOR) return MAX_FACTOR;
      return v;
   endfunction

   // advance the block sums by one source pixel, queueing a reduced pixel on block close
   task automatic accumulate_pixel(input logic [SAMPLE_W-1:0] s0, s1, s2);
      int unsigned       w, h, f, slot, count, base, avg;
      int unsigned       s [3];
      logic              last_col, last_row, col_end, row_end;
      reduced_pixel_type px;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      f = clamp_factor(factor_reg);
      s[0] = s0;
      s[1] = rgb_mode ? s1 : 0;
      s[2] = rgb_mode ? s2 : 0;
      last_col = pixel_column + 1 >= w;
      last_row = pixel_row + 1 >= h;
      col_end  = last_col || column_offset + 1 >= f;
      row_end  = last_row || row_offset + 1 >= f;
      slot     = (pixel_column / f) % MAX_OUT_WIDTH;
      for (int c = 0; c < 3; c++) segment_sums[c] += s[c];
      if (col_end) begin
         for (int c = 0; c < 3; c++) begin
            base = (row_offset == 0) ? 0 : block_column_sums[slot][c];
            block_column_sums[slot][c] = base + segment_sums[c];
            segment_sums[c] = 0;
         end
         if (row_end) begin
            count     = (column_offset + 1) * (row_offset + 1);
            px.column = SLOT_W'(pixel_column / f);
            px.row    = SLOT_W'(pixel_row / f);
            for (int c = 0; c < 3; c++) begin
               avg = block_column_sums[slot][c] / count;
               px.mean[c] = (avg > 255) ? 8'd255 : avg[7:0];
            end
            px.done = last_col && last_row;
            reduced_pixel_queue.push_back(px);
         end
         column_offset = 0;
      end else begin
         column_offset++;
      end
      if (last_col) begin
         pixel_column  = 0;
         column_offset = 0;
         for (int c = 0; c < 3; c++) segment_sums[c] = 0;
         row_offset = row_end ? 0 : row_offset + 1;
         if (last_row) begin
            pixel_row  = 0;
            row_offset = 0;
         end else begin
            pixel_row++;
         end
      end else begin
         pixel_column++;
      end
   endtask

   // compare one reduced pixel transfer against the oldest prediction
   task automatic check_reduced_pixel();
      reduced_pixel_type want;
      logic              bad;
      if (reduced_pixel_queue.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected reduced pixel col %0d row %0d", $realtime,
                     rsp_mon.out_column, rsp_mon.out_row);
         return;
      end
      want = reduced_pixel_queue.pop_front();
      bad = want.column !== rsp_mon.out_column || want.row !== rsp_mon.out_row ||
            want.mean[0] !== rsp_mon.average_zero ||
            want.mean[1] !== rsp_mon.average_one ||
            want.mean[2] !== rsp_mon.average_two || want.done !== rsp_mon.image_done;
      if (bad) begin
         fail_count++;
         if (fail_count <= 10)
            $display({"%0t: expected col %0d row %0d means %0d %0d %0d done %0d,",
                      " got col %0d row %0d means %0d %0d %0d done %0d"},
                     $realtime, want.column, want.row, want.mean[0], want.mean[1],
                     want.mean[2], want.done, rsp_mon.out_column, rsp_mon.out_row,
                     rsp_mon.average_zero, rsp_mon.average_one, rsp_mon.average_two,
                     rsp_mon.image_done);
      end
   endtask

   // watch register writes and both channels
   always @(posedge clock) begin
      if (reset) begin
         fail_count    = 0;
         width_reg     = 640;
         height_reg    = 480;
         factor_reg    = 2;
         rgb_mode      = 1'b0;
         pixel_column  = 0;
         pixel_row     = 0;
         column_offset = 0;
         row_offset    = 0;
         for (int c = 0; c < 3; c++) segment_sums[c] = 0;
         reduced_pixel_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_write_data;
               CSR_IMAGE_HEIGHT: height_reg = csr_write_data;
               CSR_BLOCK_FACTOR: factor_reg = csr_write_data[FACTOR_W-1:0];
               CSR_COLOR_MODE:   rgb_mode   = csr_write_data[0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) check_reduced_pixel();
         if (req_mon.valid && req_mon.ready)
            accumulate_pixel(req_mon.sample_zero, req_mon.sample_one, req_mon.sample_two);
      end
      pending_count <= reduced_pixel_queue.size();
   end

endmodule

### tb/box_average_downsampler_tb.sv
// top of the box average downsampler testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module box_average_downsampler_tb;
   import bad_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   csr_index_type        csr_index;
   logic [SIZE_W-1:0]    csr_write_data;
   int                   fail_count, pending_count;
   int                   pixels_sent;
   logic                 quiet;

   bad_req_if req_chan ();
   bad_rsp_if rsp_chan ();

   box_average_downsampler DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source)
   );

   pixel_block_checker block_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // gap length: mostly none, sometimes short, now and then long, none in quiet stretches
   function automatic int pick_gap();
      if (quiet) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   // receiver stalls
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left     <= pick_gap();
      end
   end

   task automatic write_register(input csr_index_type idx, input logic [SIZE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // let every reduced pixel drain, then let in-flight segments settle
   task automatic wait_for_idle();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one pixel transfer, valid held high across back-to-back transfers
   task automatic send_pixel(input logic [SAMPLE_W-1:0] s0, s1, s2);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample_zero <= s0;
      req_chan.sample_one  <= s1;
      req_chan.sample_two  <= s2;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pixels_sent++;
   endtask

   // configure and stream one whole image; pattern 0 random, 1 extremes, 2 all full scale
   task automatic run_image(input logic [SIZE_W-1:0] w, h, input logic [FACTOR_W-1:0] f,
                            input logic rgb, input int pattern, input logic hold_midway);
      int ew, eh, total;
      logic [SAMPLE_W-1:0] a, b, c;
      wait_for_idle();
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      write_register(CSR_BLOCK_FACTOR, SIZE_W'(f));
      write_register(CSR_COLOR_MODE, SIZE_W'(rgb));
      ew = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      eh = (h == 0) ? 1 : (h > MAX_WIDTH) ? MAX_WIDTH : h;
      total = ew * eh;
      for (int i = 0; i < total; i++) begin
         case (pattern)
            1: begin
               a = (i % 2) ? 8'hFF : 8'h00;
               b = (i % 3) ? 8'h00 : 8'hFF;
               c = ((i / 2) % 2) ? 8'hFF : 8'h00;
            end
            2: begin
               a = 8'hFF; b = 8'hFF; c = 8'hFF;
            end
            default: begin
               a = SAMPLE_W'($urandom);
               b = SAMPLE_W'($urandom);
               c = SAMPLE_W'($urandom);
            end
         endcase
         send_pixel(a, b, c);
         if (hold_midway && i == total / 2) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int target;
      logic [SIZE_W-1:0]   rw, rh;
      logic [FACTOR_W-1:0] rf;
      csr_write_enable     <= 1'b0;
      csr_index            <= CSR_IMAGE_WIDTH;
      csr_write_data       <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.sample_zero <= '0;
      req_chan.sample_one  <= '0;
      req_chan.sample_two  <= '0;
      reset                <= 1'b1;
      pixels_sent = 0;
      quiet       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small images, most with extreme samples, partial edges, clamped sizes
      run_image(13'd3, 13'd3, 5'd2, 1'b1, 1, 1'b0);
      run_image(13'd5, 13'd4, 5'd3, 1'b0, 2, 1'b0);
      run_image(13'd0, 13'd0, 5'd1, 1'b1, 1, 1'b0);
      run_image(13'd17, 13'd2, 5'd31, 1'b1, 2, 1'b0);
      run_image(13'd4, 13'd1, 5'd0, 1'b1, 0, 1'b0);

      // random images of mostly small sizes
      target = pixels_sent + 830;
      while (pixels_sent < target) begin
         rw = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(49, 200))
                                          : SIZE_W'($urandom_range(1, 48));
         rh = SIZE_W'($urandom_range(1, 10));
         rf = ($urandom_range(0, 7) == 0) ? FACTOR_W'($urandom_range(0, 31))
                                          : FACTOR_W'($urandom_range(2, 16));
         quiet = ($urandom_range(0, 4) == 0);
         run_image(rw, rh, rf, 1'($urandom_range(0, 1)), 0, pixels_sent == target - 830);
      end
      quiet = 1'b0;

      wait_for_idle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit
   initial begin
      #60_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
